### src/prsp_pkg.sv
// ----------------------------------------------------------------------------
// prsp_pkg
// Types and constants shared by the playlist record stream parser modules.
// ----------------------------------------------------------------------------
package prsp_pkg;

	// Parser phases
	localparam logic [4:0] PH_MAGIC = 5'd0;
	localparam logic [4:0] PH_VER   = 5'd1;
	localparam logic [4:0] PH_IDX   = 5'd2;
	localparam logic [4:0] PH_CNT   = 5'd3;
	localparam logic [4:0] PH_NLEN  = 5'd4;
	localparam logic [4:0] PH_NAME  = 5'd5;
	localparam logic [4:0] PH_FLEN1 = 5'd6;
	localparam logic [4:0] PH_FMT1  = 5'd7;
	localparam logic [4:0] PH_FLEN2 = 5'd8;
	localparam logic [4:0] PH_FMT2  = 5'd9;
	localparam logic [4:0] PH_PLEN  = 5'd10;
	localparam logic [4:0] PH_PATH  = 5'd11;
	localparam logic [4:0] PH_MARK  = 5'd12;
	localparam logic [4:0] PH_TRK   = 5'd13;
	localparam logic [4:0] PH_TLEN  = 5'd14;
	localparam logic [4:0] PH_TITLE = 5'd15;
	localparam logic [4:0] PH_DUR   = 5'd16;
	localparam logic [4:0] PH_STOP  = 5'd17;

	// Result kinds
	localparam logic [2:0] K_VERSION = 3'd0;
	localparam logic [2:0] K_INDEX   = 3'd1;
	localparam logic [2:0] K_COUNT   = 3'd2;
	localparam logic [2:0] K_NAME    = 3'd3;
	localparam logic [2:0] K_PATH    = 3'd4;
	localparam logic [2:0] K_TITLE   = 3'd5;
	localparam logic [2:0] K_ENTRY   = 3'd6;
	localparam logic [2:0] K_END     = 3'd7;

	// End status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_HEADER = 3'd1;
	localparam logic [2:0] ST_BAD_PATH   = 3'd2;
	localparam logic [2:0] ST_BAD_MARKER = 3'd3;
	localparam logic [2:0] ST_TRUNCATED  = 3'd4;

	// Record markers
	localparam logic [31:0] MARK_PLAIN = 32'd6;
	localparam logic [31:0] MARK_CUE   = 32'd7;

	// Configuration register indexes and reset values
	localparam logic REG_MAX_PATH = 1'b0;
	localparam logic REG_EXT_VER  = 1'b1;
	localparam logic [15:0] MAX_PATH_RESET = 16'd8192;
	localparam logic [7:0]  EXT_VER_RESET  = 8'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} prsp_in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [15:0] track_number;
		logic        is_cue;
		logic [2:0]  status;
		logic        last;
	} prsp_out_t;

	// Results caused by one byte: up to two, in order
	typedef struct packed {
		logic [1:0] cnt;
		prsp_out_t  item0;
		prsp_out_t  item1;
	} prsp_pair_t;

	// Expected magic byte at each position
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = 8'h54;
			2'd1: b = 8'h54;
			2'd2: b = 8'h42;
			default: b = 8'h4C;
		endcase
		return b;
	endfunction

endpackage

### src/playlist_record_stream_parser_core.sv
// Results of a byte go into the registered result queue as the byte is accepted.
// Throughput: one byte per cycle while the queue has room; the result queue
// (QUEUE_DEPTH items) takes a byte only with room for two, and hands results out one at a time.
// Reset (arst_n low): parser back to the magic check, queue emptied,
// max_path_bytes = 8192, extended_version = 5.
// ----------------------------------------------------------------------------
// playlist_record_stream_parser_core
// Top level: configuration registers, byte parser and result queue.
// ----------------------------------------------------------------------------
module playlist_record_stream_parser_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 src_valid,
	output logic                 src_ready,
	input  prsp_pkg::prsp_in_t   src_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output prsp_pkg::prsp_out_t  res_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data
);
	import prsp_pkg::*;

	logic [15:0] max_path_q;
	logic [7:0]  ext_ver_q;
	logic        room;
	logic        step;
	prsp_pair_t  pair;

	assign cfg_ready = 1'b1;
	assign src_ready = room;
	assign step      = src_valid && room;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_path_q <= MAX_PATH_RESET;
			ext_ver_q  <= EXT_VER_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_PATH: max_path_q <= cfg_data;
				REG_EXT_VER:  ext_ver_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	prsp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.src      (src_data),
		.max_path (max_path_q),
		.ext_ver  (ext_ver_q),
		.res      (pair)
	);

	prsp_res_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.wr        (pair),
		.room      (room),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule

### src/prsp_parser.sv
// ----------------------------------------------------------------------------
// prsp_parser
// Byte-wise parser state and result generation; one byte per cycle while step is high.
// ----------------------------------------------------------------------------
module prsp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  prsp_pkg::prsp_in_t    src,
	input  logic [15:0]           max_path,
	input  logic [7:0]            ext_ver,
	output prsp_pkg::prsp_pair_t  res
);
	import prsp_pkg::*;

	logic [4:0]  phase_q, phase_d;
	logic [1:0]  bif_q, bif_d;
	logic [31:0] ws_q, ws_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  low_q, low_d;
	logic [31:0] hver_q, hver_d;
	logic        cue_q, cue_d;
	logic [15:0] trk_q, trk_d;
	logic [31:0] cnt_q, cnt_d;
	logic [2:0]  stop_q, stop_d;

	logic [7:0]  b;
	logic [31:0] ws_new;
	logic [31:0] word_w;
	logic        half_word;
	logic        word_done;
	logic        is_str;
	logic [4:0]  after_name;
	logic [4:0]  str_next;
	logic [2:0]  str_kind;
	logic        str_shown;
	logic        mid_v;
	prsp_out_t   mid;
	prsp_out_t   fin;
	logic [2:0]  end_st;

	assign b         = src.data_byte;
	assign ws_new    = {b, ws_q[31:8]};
	assign half_word = (phase_q == PH_MARK) || (phase_q == PH_TRK);
	assign word_done = half_word ? (bif_q >= 2'd1) : (bif_q == 2'd3);
	assign word_w    = half_word ? {16'd0, ws_new[31:16]} : ws_new;
	assign after_name = (!hver_q[31] && (hver_q >= {24'd0, ext_ver})) ? PH_FLEN1 : PH_PLEN;
	assign is_str = (phase_q == PH_NAME) || (phase_q == PH_FMT1) || (phase_q == PH_FMT2) ||
		(phase_q == PH_PATH) || (phase_q == PH_TITLE);

	// Where a string goes next and whether its units are shown
	always_comb begin
		str_next  = PH_PLEN;
		str_kind  = K_NAME;
		str_shown = 1'b0;
		case (phase_q)
			PH_NAME: begin
				str_next  = after_name;
				str_kind  = K_NAME;
				str_shown = 1'b1;
			end
			PH_PATH: begin
				str_next  = PH_MARK;
				str_kind  = K_PATH;
				str_shown = 1'b1;
			end
			PH_TITLE: begin
				str_next  = PH_DUR;
				str_kind  = K_TITLE;
				str_shown = 1'b1;
			end
			PH_FMT1: str_next = PH_FLEN2;
			default: str_next = PH_PLEN;
		endcase
	end

	// Next state and results for the byte on the input
	always_comb begin
		phase_d = phase_q;
		bif_d   = bif_q;
		ws_d    = ws_q;
		rem_d   = rem_q;
		low_d   = low_q;
		hver_d  = hver_q;
		cue_d   = cue_q;
		trk_d   = trk_q;
		cnt_d   = cnt_q;
		stop_d  = stop_q;
		mid_v   = 1'b0;
		mid     = '0;
		fin     = '0;
		end_st  = ST_OK;

		if (phase_q == PH_MAGIC) begin
			if (b != magic_byte(bif_q)) begin
				phase_d = PH_STOP;
				stop_d  = ST_BAD_HEADER;
			end else if (bif_q == 2'd3) begin
				bif_d   = 2'd0;
				phase_d = PH_VER;
			end else begin
				bif_d = bif_q + 2'd1;
			end
		end else if (is_str) begin
			// pair bytes into UTF-16 units
			if (bif_q == 2'd0) begin
				low_d = b;
				bif_d = 2'd1;
			end else begin
				if (str_shown) begin
					mid_v      = 1'b1;
					mid.kind   = str_kind;
					mid.value  = {16'd0, b, low_q};
				end
				bif_d = 2'd0;
			end
			rem_d = rem_q - 32'd1;
			if (rem_q == 32'd1) begin
				bif_d   = 2'd0;
				phase_d = str_next;
			end
		end else if (phase_q != PH_STOP) begin
			ws_d = ws_new;
			if (word_done) begin
				bif_d = 2'd0;
				case (phase_q)
					PH_VER: begin
						hver_d    = word_w;
						mid_v     = 1'b1;
						mid.kind  = K_VERSION;
						mid.value = word_w;
						phase_d   = PH_IDX;
					end
					PH_IDX: begin
						mid_v     = 1'b1;
						mid.kind  = K_INDEX;
						mid.value = word_w;
						phase_d   = PH_CNT;
					end
					PH_CNT: begin
						mid_v     = 1'b1;
						mid.kind  = K_COUNT;
						mid.value = word_w;
						phase_d   = PH_NLEN;
					end
					PH_NLEN, PH_FLEN1, PH_FLEN2: begin
						if (word_w[31]) begin
							phase_d = PH_STOP;
							stop_d  = ST_BAD_HEADER;
						end else if (word_w == 32'd0) begin
							phase_d = (phase_q == PH_NLEN) ? after_name :
								(phase_q == PH_FLEN1) ? PH_FLEN2 : PH_PLEN;
						end else begin
							rem_d   = word_w;
							phase_d = (phase_q == PH_NLEN) ? PH_NAME :
								(phase_q == PH_FLEN1) ? PH_FMT1 : PH_FMT2;
						end
					end
					PH_PLEN: begin
						if ((word_w == 32'd0) || (word_w > {16'd0, max_path})) begin
							phase_d = PH_STOP;
							stop_d  = ST_BAD_PATH;
						end else begin
							rem_d   = word_w;
							phase_d = PH_PATH;
						end
					end
					PH_MARK: begin
						if (word_w == MARK_PLAIN) begin
							cue_d   = 1'b0;
							trk_d   = 16'd0;
							phase_d = PH_TLEN;
						end else if (word_w == MARK_CUE) begin
							cue_d   = 1'b1;
							phase_d = PH_TRK;
						end else begin
							phase_d = PH_STOP;
							stop_d  = ST_BAD_MARKER;
						end
					end
					PH_TRK: begin
						trk_d   = word_w[15:0];
						phase_d = PH_TLEN;
					end
					PH_TLEN: begin
						if (word_w[31]) begin
							phase_d = PH_STOP;
							stop_d  = ST_TRUNCATED;
						end else if (word_w == 32'd0) begin
							phase_d = PH_DUR;
						end else begin
							rem_d   = word_w;
							phase_d = PH_TITLE;
						end
					end
					default: begin
						// duration word closes the record
						cnt_d            = cnt_q + 32'd1;
						mid_v            = 1'b1;
						mid.kind         = K_ENTRY;
						mid.value        = word_w;
						mid.track_number = trk_q;
						mid.is_cue       = cue_q;
						phase_d          = PH_PLEN;
					end
				endcase
			end else begin
				bif_d = bif_q + 2'd1;
			end
		end

		// Final byte: end item, then back to the start of a file
		if (src.end_of_file) begin
			if (phase_d == PH_STOP)
				end_st = stop_d;
			else if (phase_d <= PH_FMT2)
				end_st = ST_BAD_HEADER;
			else if ((phase_d == PH_PLEN) && (bif_d == 2'd0))
				end_st = ST_OK;
			else
				end_st = ST_TRUNCATED;
			fin.kind   = K_END;
			fin.value  = cnt_d;
			fin.status = end_st;
			fin.last   = 1'b1;
			phase_d = PH_MAGIC;
			bif_d   = 2'd0;
			ws_d    = 32'd0;
			rem_d   = 32'd0;
			low_d   = 8'd0;
			hver_d  = 32'd0;
			cue_d   = 1'b0;
			trk_d   = 16'd0;
			cnt_d   = 32'd0;
			stop_d  = ST_OK;
		end
		mid.last = !src.end_of_file;
	end

	// Order the results of this byte
	always_comb begin
		res = '0;
		if (mid_v) begin
			res.cnt   = src.end_of_file ? 2'd2 : 2'd1;
			res.item0 = mid;
			res.item1 = fin;
		end else begin
			res.cnt   = src.end_of_file ? 2'd1 : 2'd0;
			res.item0 = fin;
			res.item1 = mid;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			bif_q   <= 2'd0;
			ws_q    <= 32'd0;
			rem_q   <= 32'd0;
			low_q   <= 8'd0;
			hver_q  <= 32'd0;
			cue_q   <= 1'b0;
			trk_q   <= 16'd0;
			cnt_q   <= 32'd0;
			stop_q  <= ST_OK;
		end else if (step) begin
			phase_q <= phase_d;
			bif_q   <= bif_d;
			ws_q    <= ws_d;
			rem_q   <= rem_d;
			low_q   <= low_d;
			hver_q  <= hver_d;
			cue_q   <= cue_d;
			trk_q   <= trk_d;
			cnt_q   <= cnt_d;
			stop_q  <= stop_d;
		end
	end

endmodule

### src/prsp_res_queue.sv
// ----------------------------------------------------------------------------
// prsp_res_queue
// Result register queue: takes up to two items a cycle, hands out one.
// ----------------------------------------------------------------------------
module prsp_res_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  prsp_pkg::prsp_pair_t  wr,
	output logic                  room,
	output logic                  res_valid,
	input  logic                  res_ready,
	output prsp_pkg::prsp_out_t   res_data
);
	import prsp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	prsp_out_t       mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW-1:0]   wp1, wp2;
	logic [CW-1:0]   count_q;
	logic [1:0]      n_in;
	logic            pop;

	function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign n_in      = push ? wr.cnt : 2'd0;
	assign pop       = res_valid && res_ready;
	assign wp1       = incr(wp_q);
	assign wp2       = incr(wp1);
	assign room      = (count_q <= CW'(DEPTH - 2));
	assign res_valid = (count_q != '0);
	assign res_data  = mem_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (n_in != 2'd0)
			mem_q[wp_q] <= wr.item0;
		if (n_in == 2'd2)
			mem_q[wp1] <= wr.item1;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (n_in == 2'd1)
				wp_q <= wp1;
			else if (n_in == 2'd2)
				wp_q <= wp2;
			if (pop)
				rp_q <= incr(rp_q);
			count_q <= count_q + CW'(n_in) - CW'(pop);
		end
	end

endmodule
